// File: rtl/weighted_priority_event_queues_defines.svh
// Assertion helpers for the event queue block.
`ifndef WEIGHTED_PRIORITY_EVENT_QUEUES_DEFINES_SVH
`define WEIGHTED_PRIORITY_EVENT_QUEUES_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define WPEQ_ASSERT_IMP(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("wpeq assertion failed");

// Check that a condition implies another in the next cycle.
`define WPEQ_ASSERT_NXT(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("wpeq assertion failed");

`endif

// File: rtl/wpeq_pkg.sv
`default_nettype none

package wpeq_pkg;

  // Field widths
  localparam int MODE_W      = 1;
  localparam int CLASS_IN_W  = 3;
  localparam int CLASS_OUT_W = 2;
  localparam int SIZE_W      = 20;
  localparam int TAG_W       = 16;
  localparam int STATUS_W    = 3;
  localparam int WEIGHT_W    = 8;
  localparam int BYTES_W     = 24;
  localparam int ENTRY_W     = SIZE_W + TAG_W;

  // Configuration port
  localparam int REG_CLASSES     = 4;
  localparam int REG_WEIGHT_BASE = 0;
  localparam int REG_LIMIT_BASE  = REG_CLASSES;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = BYTES_W;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(1);
  localparam logic [BYTES_W-1:0]  LIMIT_RESET  = BYTES_W'(1048576);

  // Default geometry
  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int NUM_CLASSES_DEF = 4;

  typedef enum logic [MODE_W-1:0] {
    MODE_STORE = 1'b0,
    MODE_FETCH = 1'b1
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 3'd0,
    STATUS_BAD_CLASS = 3'd1,
    STATUS_BUDGET    = 3'd2,
    STATUS_FULL      = 3'd3,
    STATUS_EMPTY     = 3'd4
  } status_e;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [TAG_W-1:0]  tag;
  } entry_t;

endpackage

`default_nettype wire

// File: rtl/wpeq_if.sv
`default_nettype none

// Request channel: store or fetch command
interface wpeq_req_if;
  import wpeq_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [MODE_W-1:0]     mode;
  logic [CLASS_IN_W-1:0] class_in;
  logic [SIZE_W-1:0]     size_in;
  logic [TAG_W-1:0]      tag_in;

  modport source (output valid, mode, class_in, size_in, tag_in, input ready);
  modport sink   (input valid, mode, class_in, size_in, tag_in, output ready);
endinterface

// Response channel: status and fetched descriptor
interface wpeq_rsp_if;
  import wpeq_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  logic [CLASS_OUT_W-1:0] class_out;
  logic [SIZE_W-1:0]      size_out;
  logic [TAG_W-1:0]       tag_out;

  modport source (output valid, status, class_out, size_out, tag_out, input ready);
  modport sink   (input valid, status, class_out, size_out, tag_out, output ready);
endinterface

`default_nettype wire

// File: rtl/weighted_priority_event_queues.sv
// Weighted-priority event queues: NUM_CLASSES FIFOs of QUEUE_DEPTH (size, tag)
// descriptors share one entry RAM. The status of a store transaction lands in
// the output register at the accepting edge. A fetch transaction that finds
// every queue empty completes the same way. Any other fetch transaction goes
// through ST_READ: the scheduler picks a class and reads the head entry in the
// accepting cycle, and in the next cycle the registered read port of the entry
// RAM returns the descriptor and the class byte count is reduced. A new
// request is taken once the block is idle and the output register is free or
// being drained in the same cycle.
// The entry RAM needs no clearing pass after reset.
`default_nettype none

module weighted_priority_event_queues #(
  parameter int QUEUE_DEPTH = wpeq_pkg::QUEUE_DEPTH_DEF,
  parameter int NUM_CLASSES = wpeq_pkg::NUM_CLASSES_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  wpeq_req_if.sink                             req,
  wpeq_rsp_if.source                           rsp,
  input  wire logic                            cfg_we_i,
  input  wire logic [wpeq_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [wpeq_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import wpeq_pkg::*;

  localparam int CW    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int PW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW  = $clog2(QUEUE_DEPTH + 1);
  localparam int DEPTH = NUM_CLASSES * QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

  // Slot address of a queue position
  function automatic logic [AW-1:0] slot_addr(input logic [CW-1:0] c,
                                              input logic [PW-1:0] p);
    logic [AW-1:0] base;
    base = AW'(c) * AW'(QUEUE_DEPTH);
    return base + AW'(p);
  endfunction

  // Circular pointer advance
  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    r = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    return r;
  endfunction

  state_e state_q, state_d;

  logic                   out_valid_q, out_valid_d;
  status_e                out_status_q, out_status_d;
  logic [CLASS_OUT_W-1:0] out_class_q, out_class_d;
  logic [SIZE_W-1:0]      out_size_q, out_size_d;
  logic [TAG_W-1:0]       out_tag_q, out_tag_d;
  logic [CW-1:0]          rd_class_q, rd_class_d;

  logic [PW-1:0]       head_q [NUM_CLASSES];
  logic [PW-1:0]       head_d [NUM_CLASSES];
  logic [PW-1:0]       tail_q [NUM_CLASSES];
  logic [PW-1:0]       tail_d [NUM_CLASSES];
  logic [CNTW-1:0]     count_q [NUM_CLASSES];
  logic [CNTW-1:0]     count_d [NUM_CLASSES];
  logic [BYTES_W-1:0]  bytes_q [NUM_CLASSES];
  logic [BYTES_W-1:0]  bytes_d [NUM_CLASSES];
  logic [WEIGHT_W-1:0] wleft_q [NUM_CLASSES];
  logic [WEIGHT_W-1:0] wleft_d [NUM_CLASSES];
  logic [WEIGHT_W-1:0] cfg_weight_q [NUM_CLASSES];
  logic [BYTES_W-1:0]  cfg_limit_q [NUM_CLASSES];

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, rd_entry;
  logic [ENTRY_W-1:0] ram_rdata;

  logic               req_fire;
  logic [CW-1:0]      st_cls;
  logic               st_bad;
  logic [BYTES_W:0]   st_sum;
  logic               st_budget;
  logic               st_full;
  logic               hit1, hit2;
  logic [CW-1:0]      sel1, sel2;
  logic [BYTES_W-1:0] pop_bytes;

  assign req_fire = req.valid && req.ready;
  assign req.ready = (state_q == ST_IDLE) && (!out_valid_q || rsp.ready);

  assign rsp.valid     = out_valid_q;
  assign rsp.status    = out_status_q;
  assign rsp.class_out = out_class_q;
  assign rsp.size_out  = out_size_q;
  assign rsp.tag_out   = out_tag_q;

  // Store admission checks
  assign st_cls    = req.class_in[CW-1:0];
  assign st_bad    = (req.class_in >= CLASS_IN_W'(NUM_CLASSES));
  assign st_sum    = (BYTES_W+1)'(bytes_q[st_cls]) + (BYTES_W+1)'(req.size_in);
  assign st_budget = (req.size_in == '0) || (st_sum > (BYTES_W+1)'(cfg_limit_q[st_cls]));
  assign st_full   = (count_q[st_cls] == CNTW'(QUEUE_DEPTH));

  // Scheduler: first pass on classes with weight left, second on spent ones
  always_comb begin
    hit1 = 1'b0;
    hit2 = 1'b0;
    sel1 = '0;
    sel2 = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (!hit1 && (wleft_q[c] != '0) && (count_q[c] != '0)) begin
        hit1 = 1'b1;
        sel1 = CW'(c);
      end
      if (!hit2 && (wleft_q[c] == '0) && (count_q[c] != '0)) begin
        hit2 = 1'b1;
        sel2 = CW'(c);
      end
    end
  end

  assign rd_entry  = entry_t'(ram_rdata);
  assign pop_bytes = bytes_q[rd_class_q];

  // Transaction sequencing and queue bookkeeping
  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_class_d  = out_class_q;
    out_size_d   = out_size_q;
    out_tag_d    = out_tag_q;
    rd_class_d   = rd_class_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    bytes_d      = bytes_q;
    wleft_d      = wleft_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = slot_addr(st_cls, tail_q[st_cls]);
    ram_raddr    = '0;
    ram_wdata    = '{size: req.size_in, tag: req.tag_in};

    // Drop the result once taken
    if (out_valid_q && rsp.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          if (req.mode == MODE_STORE) begin
            out_valid_d = 1'b1;
            out_class_d = '0;
            out_size_d  = '0;
            out_tag_d   = '0;
            if (st_bad) begin
              out_status_d = STATUS_BAD_CLASS;
            end else if (st_budget) begin
              out_status_d = STATUS_BUDGET;
            end else if (st_full) begin
              out_status_d = STATUS_FULL;
            end else begin
              out_status_d    = STATUS_OK;
              ram_we          = 1'b1;
              tail_d[st_cls]  = ptr_inc(tail_q[st_cls]);
              count_d[st_cls] = count_q[st_cls] + CNTW'(1);
              bytes_d[st_cls] = st_sum[BYTES_W-1:0];
            end
          end else if (hit1) begin
            ram_re        = 1'b1;
            ram_raddr     = slot_addr(sel1, head_q[sel1]);
            head_d[sel1]  = ptr_inc(head_q[sel1]);
            count_d[sel1] = count_q[sel1] - CNTW'(1);
            wleft_d[sel1] = wleft_q[sel1] - WEIGHT_W'(1);
            rd_class_d    = sel1;
            state_d       = ST_READ;
          end else if (hit2) begin
            ram_re        = 1'b1;
            ram_raddr     = slot_addr(sel2, head_q[sel2]);
            head_d[sel2]  = ptr_inc(head_q[sel2]);
            count_d[sel2] = count_q[sel2] - CNTW'(1);
            wleft_d       = cfg_weight_q;
            rd_class_d    = sel2;
            state_d       = ST_READ;
          end else begin
            out_valid_d  = 1'b1;
            out_status_d = STATUS_EMPTY;
            out_class_d  = '0;
            out_size_d   = '0;
            out_tag_d    = '0;
          end
        end
      end
      ST_READ: begin
        // Return the head entry and release its bytes
        out_valid_d  = 1'b1;
        out_status_d = STATUS_OK;
        out_class_d  = CLASS_OUT_W'(rd_class_q);
        out_size_d   = rd_entry.size;
        out_tag_d    = rd_entry.tag;
        if (pop_bytes >= BYTES_W'(rd_entry.size)) begin
          bytes_d[rd_class_q] = pop_bytes - BYTES_W'(rd_entry.size);
        end else begin
          bytes_d[rd_class_q] = '0;
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      out_status_q <= STATUS_OK;
      out_class_q  <= '0;
      out_size_q   <= '0;
      out_tag_q    <= '0;
      rd_class_q   <= '0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_class_q  <= out_class_d;
      out_size_q   <= out_size_d;
      out_tag_q    <= out_tag_d;
      rd_class_q   <= rd_class_d;
    end
  end

  // Per-class pointers, counts, budgets and weights
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head_q[c]  <= '0;
        tail_q[c]  <= '0;
        count_q[c] <= '0;
        bytes_q[c] <= '0;
        wleft_q[c] <= WEIGHT_RESET;
      end
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      bytes_q <= bytes_d;
      wleft_q <= wleft_d;
    end
  end

  // Configuration registers; indexes that match no class register are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        cfg_weight_q[c] <= WEIGHT_RESET;
        cfg_limit_q[c]  <= LIMIT_RESET;
      end
    end else if (cfg_we_i) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        if (cfg_idx_i == CFG_IDX_W'(REG_WEIGHT_BASE + c)) begin
          cfg_weight_q[c] <= cfg_wdata_i[WEIGHT_W-1:0];
        end
        if (cfg_idx_i == CFG_IDX_W'(REG_LIMIT_BASE + c)) begin
          cfg_limit_q[c] <= cfg_wdata_i[BYTES_W-1:0];
        end
      end
    end
  end

  // Entry store shared by all class FIFOs
  wpeq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

// File: rtl/wpeq_ram.sv
`default_nettype none

module wpeq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/wpeq_chk.sv
`default_nettype none
`include "weighted_priority_event_queues_defines.svh"

module wpeq_chk (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             req_valid_i,
  input wire logic                             req_ready_i,
  input wire logic                             rsp_valid_i,
  input wire logic                             rsp_ready_i,
  input wire logic [wpeq_pkg::STATUS_W-1:0]    rsp_status_i,
  input wire logic [wpeq_pkg::CLASS_OUT_W-1:0] rsp_class_i,
  input wire logic [wpeq_pkg::SIZE_W-1:0]      rsp_size_i,
  input wire logic [wpeq_pkg::TAG_W-1:0]       rsp_tag_i
);
  import wpeq_pkg::*;

  logic req_fire;
  assign req_fire = req_valid_i && req_ready_i;

  // Hold a stalled result
  `WPEQ_ASSERT_NXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_tag_i) && $stable(rsp_size_i))

  // Refused or empty results carry no descriptor
  `WPEQ_ASSERT_IMP(a_fail_zero, clk_i, rst_ni, rsp_valid_i && (rsp_status_i != STATUS_OK), (rsp_class_i == '0) && (rsp_size_i == '0) && (rsp_tag_i == '0))

  // Every new result follows an accepted transaction, directly or by way of ST_READ
  `WPEQ_ASSERT_IMP(a_rsp_cause, clk_i, rst_ni, $rose(rsp_valid_i), $past(req_fire) || $past(req_fire, 2))

  // Block new requests while a result is stalled
  `WPEQ_ASSERT_IMP(a_stall_blocks, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, !req_ready_i)

endmodule

bind weighted_priority_event_queues wpeq_chk u_wpeq_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req.valid),
  .req_ready_i  (req.ready),
  .rsp_valid_i  (rsp.valid),
  .rsp_ready_i  (rsp.ready),
  .rsp_status_i (rsp.status),
  .rsp_class_i  (rsp.class_out),
  .rsp_size_i   (rsp.size_out),
  .rsp_tag_i    (rsp.tag_out)
);

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import wpeq_pkg::*;

  localparam int QUEUE_DEPTH    = QUEUE_DEPTH_DEF;
  localparam int NUM_CLASSES    = NUM_CLASSES_DEF;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct {
    mode_e                 mode;
    logic [CLASS_IN_W-1:0] cls;
    logic [SIZE_W-1:0]     size;
    logic [TAG_W-1:0]      tag;
  } event_req_t;

  typedef struct {
    status_e                status;
    logic [CLASS_OUT_W-1:0] cls;
    logic [SIZE_W-1:0]      size;
    logic [TAG_W-1:0]       tag;
  } event_rsp_t;

  typedef logic [WEIGHT_W-1:0] weight_set_t [NUM_CLASSES];
  typedef logic [BYTES_W-1:0]  limit_set_t [NUM_CLASSES];

  // Mirror the class queues and the weighted scheduler, and hold the
  // outcomes still owed by the block.
  class event_queue_scoreboard;
    logic [WEIGHT_W-1:0] weight_cfg [NUM_CLASSES];
    logic [BYTES_W-1:0]  limit_cfg [NUM_CLASSES];
    logic [WEIGHT_W-1:0] weight_left [NUM_CLASSES];
    int unsigned         queued_bytes [NUM_CLASSES];
    entry_t              held_events [NUM_CLASSES][$];
    event_rsp_t          pending_outcomes [$];
    int                  errors;
    int                  checked;

    function new();
      for (int c = 0; c < NUM_CLASSES; c++) begin
        weight_cfg[c]   = WEIGHT_RESET;
        limit_cfg[c]    = LIMIT_RESET;
        weight_left[c]  = WEIGHT_RESET;
        queued_bytes[c] = 0;
      end
      errors  = 0;
      checked = 0;
    endfunction

    // Change a weight reload value or a byte limit; weight_left holds.
    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx < REG_LIMIT_BASE)
        weight_cfg[idx - REG_WEIGHT_BASE] = data[WEIGHT_W-1:0];
      else if (idx < REG_LIMIT_BASE + REG_CLASSES)
        limit_cfg[idx - REG_LIMIT_BASE] = data[BYTES_W-1:0];
    endfunction

    function int outstanding();
      return pending_outcomes.size();
    endfunction

    // Predict the outcome of an accepted request and queue it.
    function void note_request(event_req_t r);
      event_rsp_t e;
      entry_t     ent;
      int         served;
      bit         reload;
      e.status = STATUS_OK;
      e.cls    = '0;
      e.size   = '0;
      e.tag    = '0;
      served   = -1;
      reload   = 1'b0;
      if (r.mode == MODE_STORE) begin
        // Check class, then size and budget, then room in the queue.
        if (r.cls >= NUM_CLASSES) begin
          e.status = STATUS_BAD_CLASS;
        end else if (r.size == 0 || queued_bytes[r.cls] + r.size > limit_cfg[r.cls]) begin
          e.status = STATUS_BUDGET;
        end else if (held_events[r.cls].size() >= QUEUE_DEPTH) begin
          e.status = STATUS_FULL;
        end else begin
          ent.size = r.size;
          ent.tag  = r.tag;
          held_events[r.cls].push_back(ent);
          queued_bytes[r.cls] += r.size;
        end
      end else begin
        // First pass: lowest class with weight left; second pass: spent weight.
        for (int c = 0; c < NUM_CLASSES; c++)
          if (served < 0 && weight_left[c] != 0 && held_events[c].size() != 0) served = c;
        if (served >= 0) begin
          weight_left[served] = weight_left[served] - 1'b1;
        end else begin
          for (int c = 0; c < NUM_CLASSES; c++)
            if (served < 0 && weight_left[c] == 0 && held_events[c].size() != 0) served = c;
          reload = (served >= 0);
        end
        if (served < 0) begin
          e.status = STATUS_EMPTY;
        end else begin
          ent = held_events[served].pop_front();
          queued_bytes[served] = (queued_bytes[served] >= ent.size) ?
                                 queued_bytes[served] - ent.size : 0;
          e.cls  = CLASS_OUT_W'(served);
          e.size = ent.size;
          e.tag  = ent.tag;
          if (reload) weight_left = weight_cfg;
        end
      end
      pending_outcomes.push_back(e);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: result %0d %s mismatch: expected %0h, actual %0h",
                 $time, checked, name, want, got);
        errors++;
      end
    endfunction

    // Compare one accepted result with the oldest prediction.
    function void check_outcome(logic [STATUS_W-1:0] status, logic [CLASS_OUT_W-1:0] cls,
                                logic [SIZE_W-1:0] size, logic [TAG_W-1:0] tag);
      event_rsp_t e;
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual status %0h class %0h",
                 $time, status, cls);
        errors++;
        return;
      end
      e = pending_outcomes.pop_front();
      compare_field("status", e.status, status);
      compare_field("class_out", e.cls, cls);
      compare_field("size_out", e.size, size);
      compare_field("tag_out", e.tag, tag);
      checked++;
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  bit                    steady = 1'b0;
  int                    quiet_cycles = 0;

  event_queue_scoreboard book = new();

  wpeq_req_if req_ch ();
  wpeq_rsp_if rsp_ch ();

  weighted_priority_event_queues #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .NUM_CLASSES (NUM_CLASSES)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Accept results and, outside steady mode, stall the response channel at random.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_ch.valid && rsp_ch.ready)
        book.check_outcome(rsp_ch.status, rsp_ch.class_out, rsp_ch.size_out, rsp_ch.tag_out);
      rsp_ch.ready <= steady || ($urandom_range(99) >= 10);
    end else begin
      rsp_ch.ready <= 1'b0;
    end
  end

  // Abort when no transaction moves on either channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog: no transaction for %0d cycles", $time, quiet_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic event_req_t make_request(mode_e m, logic [CLASS_IN_W-1:0] cls,
                                              logic [SIZE_W-1:0] size, logic [TAG_W-1:0] tag);
    event_req_t r;
    r.mode = m;
    r.cls  = cls;
    r.size = size;
    r.tag  = tag;
    return r;
  endfunction

  // Mostly valid classes and small sizes, with zero and full-range sizes mixed in.
  function automatic event_req_t random_request(int store_pct);
    event_req_t r;
    int         pick;
    r.mode = ($urandom_range(99) < store_pct) ? MODE_STORE : MODE_FETCH;
    r.cls  = ($urandom_range(9) == 0) ? CLASS_IN_W'($urandom_range(7, 4))
                                      : CLASS_IN_W'($urandom_range(3));
    pick   = $urandom_range(19);
    if (pick == 0)     r.size = '0;
    else if (pick < 3) r.size = SIZE_W'($urandom);
    else               r.size = SIZE_W'($urandom_range(4096, 1));
    r.tag  = TAG_W'($urandom);
    return r;
  endfunction

  // Present one request, with random idle cycles ahead of it, until accepted.
  task automatic send_request(event_req_t r);
    if (!steady) begin
      while ($urandom_range(99) < 10) begin
        req_ch.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    req_ch.valid    <= 1'b1;
    req_ch.mode     <= r.mode;
    req_ch.class_in <= r.cls;
    req_ch.size_in  <= r.size;
    req_ch.tag_in   <= r.tag;
    do @(posedge clk_i); while (!req_ch.ready);
    book.note_request(r);
  endtask

  task automatic send_random(int count, int store_pct);
    for (int i = 0; i < count; i++) send_request(random_request(store_pct));
  endtask

  // Push small events into one class, past the point where it is full.
  task automatic fill_class(logic [CLASS_IN_W-1:0] cls, int count);
    for (int i = 0; i < count; i++)
      send_request(make_request(MODE_STORE, cls, SIZE_W'($urandom_range(16, 1)),
                                TAG_W'($urandom)));
  endtask

  // Hold requests off until every result is back and the block is idle.
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (book.outstanding() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    book.write_register(idx, data);
  endtask

  task automatic program_settings(weight_set_t w, limit_set_t lim);
    for (int c = 0; c < REG_CLASSES; c++)
      cfg_write(CFG_IDX_W'(REG_WEIGHT_BASE + c), CFG_DATA_W'(w[c]));
    for (int c = 0; c < REG_CLASSES; c++)
      cfg_write(CFG_IDX_W'(REG_LIMIT_BASE + c), CFG_DATA_W'(lim[c]));
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    weight_set_t w;
    limit_set_t  lim;
    req_ch.valid    <= 1'b0;
    req_ch.mode     <= MODE_STORE;
    req_ch.class_in <= '0;
    req_ch.size_in  <= '0;
    req_ch.tag_in   <= '0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= '0;
    cfg_wdata_i     <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: refusals, exact budget fit, one full weighted round.
    send_request(make_request(MODE_FETCH, 3'd0, 20'd0, 16'h0000));
    send_request(make_request(MODE_STORE, 3'd4, 20'd5, 16'h0001));
    send_request(make_request(MODE_STORE, 3'd7, 20'hFFFFF, 16'hFFFF));
    send_request(make_request(MODE_STORE, 3'd5, 20'd0, 16'h0002));
    send_request(make_request(MODE_STORE, 3'd0, 20'd0, 16'h0003));
    send_request(make_request(MODE_STORE, 3'd0, 20'hFFFFF, 16'hFFFF));
    send_request(make_request(MODE_STORE, 3'd0, 20'd2, 16'h0004));
    send_request(make_request(MODE_STORE, 3'd0, 20'd1, 16'h0000));
    send_request(make_request(MODE_STORE, 3'd1, 20'd100, 16'h1234));
    send_request(make_request(MODE_STORE, 3'd2, 20'd200, 16'hABCD));
    send_request(make_request(MODE_STORE, 3'd3, 20'd1, 16'h0000));
    send_request(make_request(MODE_STORE, 3'd1, 20'd7, 16'h8000));
    for (int i = 0; i < 8; i++)
      send_request(make_request(MODE_FETCH, 3'd7, 20'hFFFFF, 16'hFFFF));
    wait_idle();

    // Extremes: zero and full weights, zero and full byte limits.
    w   = '{8'd0, 8'd255, 8'd3, 8'd1};
    lim = '{24'hFFFFFF, 24'd0, 24'd5000, 24'd1048575};
    program_settings(w, lim);
    fill_class(3'd0, 66);
    send_request(make_request(MODE_STORE, 3'd0, 20'd0, 16'h5555));
    send_random(60, 45);
    // Let every outstanding result drain before resuming.
    wait_idle();
    send_random(60, 45);
    wait_idle();

    // All weights spent, random limits, no idling on either side.
    w   = '{8'd0, 8'd0, 8'd0, 8'd0};
    for (int c = 0; c < NUM_CLASSES; c++) lim[c] = BYTES_W'($urandom);
    program_settings(w, lim);
    steady = 1'b1;
    send_random(130, 60);
    wait_idle();
    steady = 1'b0;

    // Limits dropped below queued bytes: refuse stores, keep draining.
    w   = '{8'd255, 8'd255, 8'd255, 8'd255};
    lim = '{24'd1, 24'd1, 24'd1, 24'd1};
    program_settings(w, lim);
    send_random(100, 30);
    wait_idle();

    // Random small weights and limits, then fill one class and follow with fetches only.
    for (int c = 0; c < NUM_CLASSES; c++) begin
      w[c]   = WEIGHT_W'($urandom_range(4));
      lim[c] = ($urandom_range(3) == 0) ? BYTES_W'($urandom)
                                        : BYTES_W'($urandom_range(200000, 2000));
    end
    program_settings(w, lim);
    send_random(110, 55);
    fill_class(3'd2, 66);
    send_random(40, 0);

    wait_idle();
    repeat (4) @(posedge clk_i);
    if (book.errors == 0 && book.outstanding() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
